// ===== rtl/lrl_pkg.sv =====
// Shared constants, codes, handshake structs and a helper for the LRU recency list.
`default_nettype none

package lrl_pkg;

    localparam int CAPACITY = 64;
    localparam int KEY_BITS = 32;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMD_W    = 3;
    localparam int STAT_W   = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_TOUCH  = 3'd1,
        CMD_QUERY  = 3'd2,
        CMD_REMOVE = 3'd3,
        CMD_POP    = 3'd4
    } t_cmd_code;

    typedef enum logic [STAT_W-1:0] {
        ST_OK          = 3'd0,
        ST_NOT_PRESENT = 3'd1,
        ST_PRESENT     = 3'd2,
        ST_FULL        = 3'd3,
        ST_EMPTY       = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        SEL_HIT    = 2'd0,
        SEL_FREE   = 2'd1,
        SEL_OLDEST = 2'd2
    } t_slot_sel;

    // controller -> datapath
    typedef struct packed {
        logic      capture;
        t_slot_sel slot_sel;
        logic      look;
        logic      unlink;
        logic      drop;
        logic      link_move;
        logic      link_ins;
        logic      read_old;
        logic      finish;
        t_status   status;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic hit;
        logic empty;
        logic full;
        logic at_newest;
        logic out_free;
    } t_dp_stat;

    // one-hot (or all-zero) vector to slot index
    function automatic logic [SLOT_W-1:0] onehot_to_idx(input logic [CAPACITY-1:0] v);
        logic [SLOT_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            idx = idx | (v[i] ? SLOT_W'(i) : '0);
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lrl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lrl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/lrl_ctrl.sv =====
// Command sequencer for the LRU recency list.
`default_nettype none

module lrl_ctrl import lrl_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic [CMD_W-1:0] i_command,
    input  wire t_dp_stat         i_stat,
    output t_dp_cmd               o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_LOOK   = 6'b000010,
        S_UNLINK = 6'b000100,
        S_LINK   = 6'b001000,
        S_OLD    = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state           r_state, n_state;
    logic [CMD_W-1:0] r_cmd, n_cmd;
    t_status          r_status, n_status;
    t_slot_sel        sel;

    always_comb begin
        case (r_cmd)
            CMD_INSERT: sel = SEL_FREE;
            CMD_POP:    sel = SEL_OLDEST;
            default:    sel = SEL_HIT;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_status = r_status;
        o_cmd          = '0;
        o_cmd.slot_sel = sel;
        o_cmd.status   = r_status;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_cmd         = i_command;
                    n_state       = S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.look = 1'b1;
                n_status   = ST_OK;
                n_state    = S_OLD;
                case (r_cmd)
                    CMD_INSERT: begin
                        if (i_stat.hit) begin
                            n_status = ST_PRESENT;
                        end else if (i_stat.full) begin
                            n_status = ST_FULL;
                        end else begin
                            n_state = S_LINK;
                        end
                    end
                    CMD_TOUCH: begin
                        if (!i_stat.hit) begin
                            n_status = ST_NOT_PRESENT;
                        end else if (!i_stat.at_newest) begin
                            n_state = S_UNLINK;
                        end
                    end
                    CMD_QUERY: begin
                        n_status = i_stat.hit ? ST_OK : ST_NOT_PRESENT;
                    end
                    CMD_REMOVE: begin
                        if (!i_stat.hit) begin
                            n_status = ST_NOT_PRESENT;
                        end else begin
                            n_state = S_UNLINK;
                        end
                    end
                    CMD_POP: begin
                        if (i_stat.empty) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_state = S_UNLINK;
                        end
                    end
                    default: begin
                        n_status = ST_OK;
                    end
                endcase
            end
            S_UNLINK: begin
                o_cmd.unlink = 1'b1;
                if (r_cmd == CMD_TOUCH) begin
                    n_state = S_LINK;
                end else begin
                    o_cmd.drop = 1'b1;
                    n_state    = S_OLD;
                end
            end
            S_LINK: begin
                o_cmd.link_ins  = (r_cmd == CMD_INSERT);
                o_cmd.link_move = (r_cmd != CMD_INSERT);
                n_state         = S_OLD;
            end
            S_OLD: begin
                o_cmd.read_old = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                // keep the key RAM on the oldest slot while the result waits
                o_cmd.read_old = 1'b1;
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cmd    <= '0;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_cmd    <= n_cmd;
            r_status <= n_status;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lrl_dp.sv =====
// Datapath: key CAM, used bits, link and key RAMs, list pointers, result register.
`default_nettype none

module lrl_dp import lrl_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [KEY_BITS-1:0] i_key,
    input  wire t_dp_cmd             i_cmd,
    output t_dp_stat                 o_stat,
    input  wire logic                i_out_ready,
    output logic                     o_out_valid,
    output logic [STAT_W-1:0]        o_status,
    output logic [KEY_BITS-1:0]      o_removed_key,
    output logic [KEY_BITS-1:0]      o_oldest_key,
    output logic                     o_oldest_valid,
    output logic [CNT_W-1:0]         o_entry_count
);

    // control state
    logic [CAPACITY-1:0] r_used;
    logic [SLOT_W-1:0]   r_newest;
    logic [SLOT_W-1:0]   r_oldest;
    logic [CNT_W-1:0]    r_count;
    logic                r_out_valid;

    // payload
    logic [KEY_BITS-1:0] r_cam [CAPACITY];
    logic [CAPACITY-1:0] r_hit_vec;
    logic [KEY_BITS-1:0] r_key;
    logic [SLOT_W-1:0]   r_slot;
    logic [KEY_BITS-1:0] r_removed;
    logic [STAT_W-1:0]   r_o_status;
    logic [KEY_BITS-1:0] r_o_removed;
    logic [KEY_BITS-1:0] r_o_oldest_key;
    logic                r_o_oldest_valid;
    logic [CNT_W-1:0]    r_o_count;

    logic [CAPACITY-1:0] hit_now;
    logic [CAPACITY-1:0] free_oh;
    logic [SLOT_W-1:0]   hit_idx;
    logic [SLOT_W-1:0]   free_idx;
    logic [SLOT_W-1:0]   target;
    logic                s_newest;
    logic                s_oldest;
    logic                not_empty;

    logic                older_we, newer_we, key_we;
    logic [SLOT_W-1:0]   older_wa, older_wd, newer_wa, newer_wd;
    logic [SLOT_W-1:0]   older_rd, newer_rd;
    logic [SLOT_W-1:0]   key_ra;
    logic [KEY_BITS-1:0] key_rd;

    // parallel key compare
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            hit_now[i] = r_used[i] && (r_cam[i] == i_key);
        end
    end

    // lowest free slot: isolate lowest zero of the used bits
    assign free_oh  = ~r_used & (r_used + CAPACITY'(1));
    assign free_idx = onehot_to_idx(free_oh);
    assign hit_idx  = onehot_to_idx(r_hit_vec);

    always_comb begin
        case (i_cmd.slot_sel)
            SEL_FREE:   target = free_idx;
            SEL_OLDEST: target = r_oldest;
            default:    target = hit_idx;
        endcase
    end

    assign s_newest  = (r_slot == r_newest);
    assign s_oldest  = (r_slot == r_oldest);
    assign not_empty = (r_count != '0);

    assign o_stat.hit       = |r_hit_vec;
    assign o_stat.empty     = !not_empty;
    assign o_stat.full      = (r_count == CNT_W'(CAPACITY));
    assign o_stat.at_newest = (hit_idx == r_newest);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    // link RAM write ports: unlink splices neighbors, link hangs slot on newest end
    assign older_we = (i_cmd.unlink && !s_newest) || i_cmd.link_move
                    || (i_cmd.link_ins && not_empty);
    assign older_wa = i_cmd.unlink ? newer_rd : r_slot;
    assign older_wd = i_cmd.unlink ? older_rd : r_newest;

    assign newer_we = (i_cmd.unlink && !s_oldest) || i_cmd.link_move
                    || (i_cmd.link_ins && not_empty);
    assign newer_wa = i_cmd.unlink ? older_rd : r_newest;
    assign newer_wd = i_cmd.unlink ? newer_rd : r_slot;

    assign key_we = i_cmd.link_ins;
    assign key_ra = i_cmd.read_old ? r_oldest : target;

    lrl_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_older_ram (
        .i_clk     (i_clk),
        .i_wr_en   (older_we),
        .i_wr_addr (older_wa),
        .i_wr_data (older_wd),
        .i_rd_addr (target),
        .o_rd_data (older_rd)
    );

    lrl_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_newer_ram (
        .i_clk     (i_clk),
        .i_wr_en   (newer_we),
        .i_wr_addr (newer_wa),
        .i_wr_data (newer_wd),
        .i_rd_addr (target),
        .o_rd_data (newer_rd)
    );

    lrl_ram #(.WIDTH(KEY_BITS), .DEPTH(CAPACITY)) u_key_ram (
        .i_clk     (i_clk),
        .i_wr_en   (key_we),
        .i_wr_addr (r_slot),
        .i_wr_data (r_key),
        .i_rd_addr (key_ra),
        .o_rd_data (key_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_newest    <= '0;
            r_oldest    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.unlink) begin
                if (s_newest) begin
                    r_newest <= older_rd;
                end
                if (s_oldest) begin
                    r_oldest <= newer_rd;
                end
            end
            if (i_cmd.drop) begin
                r_used[r_slot] <= 1'b0;
                r_count        <= r_count - CNT_W'(1);
            end
            if (i_cmd.link_move) begin
                r_newest <= r_slot;
            end
            if (i_cmd.link_ins) begin
                r_used[r_slot] <= 1'b1;
                r_count        <= r_count + CNT_W'(1);
                r_newest       <= r_slot;
                if (!not_empty) begin
                    r_oldest <= r_slot;
                end
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_key     <= i_key;
            r_hit_vec <= hit_now;
            r_removed <= '0;
        end
        if (i_cmd.look) begin
            r_slot <= target;
        end
        if (i_cmd.drop) begin
            r_removed <= key_rd;
        end
        if (i_cmd.link_ins) begin
            r_cam[r_slot] <= r_key;
        end
        if (i_cmd.finish) begin
            r_o_status       <= i_cmd.status;
            r_o_removed      <= r_removed;
            r_o_oldest_key   <= not_empty ? key_rd : '0;
            r_o_oldest_valid <= not_empty;
            r_o_count        <= r_count;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_o_status;
    assign o_removed_key  = r_o_removed;
    assign o_oldest_key   = r_o_oldest_key;
    assign o_oldest_valid = r_o_oldest_valid;
    assign o_entry_count  = r_o_count;

endmodule

`default_nettype wire

// ===== rtl/lru_recency_list_unit.sv =====
// Top level of the LRU recency list: sequencer, datapath and checks.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------------
//  request  | i_in_valid / o_in_ready    | i_command[2:0], i_key[31:0]
//  result   | o_out_valid / i_out_ready  | o_status[2:0], o_removed_key[31:0],
//           |                            | o_oldest_key[31:0], o_oldest_valid,
//           |                            | o_entry_count[6:0]
//
// One request is worked on at a time. Every request passes the look, oldest-key
// read and result states; an insert adds a link state, a remove or pop an unlink
// state, and a touch that moves an entry adds both. The chain of link RAM reads
// (registered) feeding the splice writes sets this sequence of states.
// Synchronous active-low reset empties the list at once (used bits are flops);
// key and link RAMs need no clearing pass.
// A result held in the output register does not block accepting the next
// request; the sequencer only waits before loading a new result over it.
`default_nettype none

module lru_recency_list_unit import lrl_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [CMD_W-1:0]    i_command,
    input  wire logic [KEY_BITS-1:0] i_key,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [STAT_W-1:0]        o_status,
    output logic [KEY_BITS-1:0]      o_removed_key,
    output logic [KEY_BITS-1:0]      o_oldest_key,
    output logic                     o_oldest_valid,
    output logic [CNT_W-1:0]         o_entry_count
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencer: one state per dependent RAM step
    lrl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_command  (i_command),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // storage, lookup and result register
    lrl_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_key          (i_key),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_removed_key  (o_removed_key),
        .o_oldest_key   (o_oldest_key),
        .o_oldest_valid (o_oldest_valid),
        .o_entry_count  (o_entry_count)
    );

    // ---- checks ----

    // count never passes capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_entry_count <= CNT_W'(CAPACITY)))
        else $error("entry count above capacity");

    // oldest mark tracks count; empty list reports zero key
    a_oldest_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_oldest_valid == (o_entry_count != '0))
                        && (o_oldest_valid || (o_oldest_key == '0)))
        else $error("oldest mark inconsistent with count");

    // only a successful command may report a removed key
    a_removed_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |-> (o_removed_key == '0))
        else $error("removed key on failed command");

    // a request is worked on alone
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted while busy");

endmodule

`default_nettype wire
